@@ hw/rtl/wma_pkg.sv @@
// ----------------------------------------------------------------------------
// wma_pkg
// Shared widths, reset values, state encoding and controller/datapath
// command and status structures for the weighted moving average block.
// ----------------------------------------------------------------------------
package wma_pkg;

  localparam int PRICE_W        = 32;   // price and average field width
  localparam int WIN_FIELD_W    = 9;    // window_used field width
  localparam int PERIOD_W       = 9;    // period register width
  localparam int PERIOD_RESET   = 20;
  localparam int MAX_PERIOD_DEF = 256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_ACC,
    ST_ABS,
    ST_NUM,
    ST_DIV,
    ST_OUT
  } wma_state_t;

  typedef struct packed {
    logic load;       // latch an accepted transaction
    logic fetch;      // pick window size, read the oldest sample
    logic mul;        // form weight product and divisor
    logic acc;        // update running totals and the sample ring
    logic take_abs;   // split the weighted total into sign and magnitude
    logic num;        // build the rounded numerator, start the divider
    logic div_step;   // one restoring division step
    logic publish;    // load the result register
  } wma_cmd_t;

  typedef struct packed {
    logic div_last;   // the current division step is the final one
    logic out_free;   // the result register can take a new result
  } wma_status_t;

endpackage

@@ hw/rtl/wma_ifs.sv @@
// ----------------------------------------------------------------------------
// wma_bar_if / wma_result_if
// Valid/ready channels for incoming price bars and outgoing averages.
// ----------------------------------------------------------------------------
interface wma_bar_if;
  logic                               valid;
  logic                               ready;
  logic signed [wma_pkg::PRICE_W-1:0] price;
  logic                               restart;

  modport source (output valid, output price, output restart, input ready);
  modport sink   (input valid, input price, input restart, output ready);
endinterface

interface wma_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [wma_pkg::PRICE_W-1:0]     average;
  logic        [wma_pkg::WIN_FIELD_W-1:0] window_used;

  modport source (output valid, output average, output window_used, input ready);
  modport sink   (input valid, input average, input window_used, output ready);
endinterface

@@ hw/rtl/wma_ram.sv @@
// ----------------------------------------------------------------------------
// wma_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/wma_ctrl.sv @@
// ----------------------------------------------------------------------------
// wma_ctrl
// Sequencer that walks one price bar through update, rounding setup,
// serial division and result hand-off.
// ----------------------------------------------------------------------------
module wma_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wma_pkg::wma_status_t status,
  output wma_pkg::wma_cmd_t    cmd
);

  wma_pkg::wma_state_t state;
  wma_pkg::wma_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wma_pkg::ST_IDLE:  if (in_valid) state_next = wma_pkg::ST_FETCH;
      wma_pkg::ST_FETCH: state_next = wma_pkg::ST_MUL;
      wma_pkg::ST_MUL:   state_next = wma_pkg::ST_ACC;
      wma_pkg::ST_ACC:   state_next = wma_pkg::ST_ABS;
      wma_pkg::ST_ABS:   state_next = wma_pkg::ST_NUM;
      wma_pkg::ST_NUM:   state_next = wma_pkg::ST_DIV;
      wma_pkg::ST_DIV:   if (status.div_last) state_next = wma_pkg::ST_OUT;
      wma_pkg::ST_OUT:   if (status.out_free) state_next = wma_pkg::ST_IDLE;
      default:           state_next = wma_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      wma_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      wma_pkg::ST_FETCH: cmd.fetch    = 1'b1;
      wma_pkg::ST_MUL:   cmd.mul      = 1'b1;
      wma_pkg::ST_ACC:   cmd.acc      = 1'b1;
      wma_pkg::ST_ABS:   cmd.take_abs = 1'b1;
      wma_pkg::ST_NUM:   cmd.num      = 1'b1;
      wma_pkg::ST_DIV:   cmd.div_step = 1'b1;
      wma_pkg::ST_OUT:   cmd.publish  = status.out_free;
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/wma_datapath.sv @@
// ----------------------------------------------------------------------------
// wma_datapath
// Sample ring, running sums, weight multiplier, restoring divider and the
// result register of the weighted moving average.
// ----------------------------------------------------------------------------
module wma_datapath #(
  parameter int MAX_PERIOD = wma_pkg::MAX_PERIOD_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  wma_pkg::wma_cmd_t                      cmd,
  output wma_pkg::wma_status_t                   status,
  input  logic                                   cfg_we,
  input  logic        [wma_pkg::PERIOD_W-1:0]    cfg_wdata,
  input  logic signed [wma_pkg::PRICE_W-1:0]     price,
  input  logic                                   restart,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output logic signed [wma_pkg::PRICE_W-1:0]     res_average,
  output logic        [wma_pkg::WIN_FIELD_W-1:0] res_window
);

  localparam int PW      = wma_pkg::PRICE_W;
  localparam int PERIOD_MAX_RAW = (1 << wma_pkg::PERIOD_W) - 1;
  localparam int WIN_LIM = (MAX_PERIOD < PERIOD_MAX_RAW) ? MAX_PERIOD : PERIOD_MAX_RAW;
  localparam int WIN_W   = $clog2(WIN_LIM + 1);
  localparam int PTR_W   = $clog2(MAX_PERIOD);
  localparam int IDX_W   = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 1;
  localparam int SUM_W   = PW + WIN_W;
  localparam int WSUM_W  = PW + 2 * WIN_W;
  localparam int PROD_W  = PW + WIN_W + 1;
  localparam int DEN_W   = 2 * WIN_W;
  localparam int NUM_W   = WSUM_W + 1;
  localparam int CNT_W   = $clog2(NUM_W);

  logic        [wma_pkg::PERIOD_W-1:0] period;
  logic        [WIN_W-1:0]             p_eff;
  logic signed [PW-1:0]                x;
  logic        [PTR_W-1:0]             wp;
  logic        [WIN_W-1:0]             nbars;
  logic signed [SUM_W-1:0]             sum;
  logic signed [WSUM_W-1:0]            wsum;
  logic                                full;
  logic        [WIN_W-1:0]             n;
  logic signed [PROD_W-1:0]            prod;
  logic        [DEN_W-1:0]             den;
  logic signed [WSUM_W-1:0]            base;
  logic                                neg;
  logic        [WSUM_W-1:0]            mag;
  logic        [NUM_W-1:0]             quo;
  logic        [DEN_W-1:0]             rem;
  logic        [CNT_W-1:0]             cnt;
  logic        [PW-1:0]                ring_rdata;
  logic        [PTR_W-1:0]             old_idx;
  logic        [IDX_W-1:0]             wp_ext;
  logic        [IDX_W-1:0]             p_ext;
  logic signed [SUM_W-1:0]             oldest;
  logic        [DEN_W:0]               rem_sh;
  logic                                take_bit;
  logic        [PTR_W-1:0]             wp_inc;
  logic                                series_clear;

  // Period zero acts as one bar; anything above the ring depth saturates.
  always_comb begin
    if (period == '0) begin
      p_eff = WIN_W'(1);
    end else if (int'(period) > MAX_PERIOD) begin
      p_eff = WIN_W'(MAX_PERIOD);
    end else begin
      p_eff = WIN_W'(period);
    end
  end

  // Oldest sample in a full window sits p_eff slots behind the write pointer.
  always_comb begin
    wp_ext = IDX_W'(wp);
    p_ext  = IDX_W'(p_eff);
    if (wp_ext >= p_ext) begin
      old_idx = PTR_W'(wp_ext - p_ext);
    end else begin
      old_idx = PTR_W'(wp_ext + IDX_W'(MAX_PERIOD) - p_ext);
    end
  end

  assign wp_inc = (int'(wp) == MAX_PERIOD - 1) ? '0 : wp + PTR_W'(1);
  assign oldest = full ? SUM_W'(signed'(ring_rdata)) : '0;

  wma_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_PERIOD)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.acc),
    .waddr (wp),
    .wdata (x),
    .re    (cmd.fetch),
    .raddr (old_idx),
    .rdata (ring_rdata)
  );

  assign series_clear = cfg_we || (cmd.load && restart);

  // Period register and running series state.
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= wma_pkg::PERIOD_W'(wma_pkg::PERIOD_RESET);
      wp     <= '0;
      nbars  <= '0;
      sum    <= '0;
      wsum   <= '0;
    end else begin
      if (cfg_we) begin
        period <= cfg_wdata;
      end
      if (series_clear) begin
        wp    <= '0;
        nbars <= '0;
        sum   <= '0;
        wsum  <= '0;
      end else if (cmd.acc) begin
        wp    <= wp_inc;
        nbars <= n;
        sum   <= sum + SUM_W'(x) - oldest;
        wsum  <= base + WSUM_W'(prod);
      end
    end
  end

  // Per-transaction working registers and the serial divider.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= price;
    end
    if (cmd.fetch) begin
      full <= (nbars >= p_eff);
      n    <= (nbars >= p_eff) ? p_eff : nbars + WIN_W'(1);
    end
    if (cmd.mul) begin
      prod <= signed'({1'b0, n}) * x;
      den  <= DEN_W'(n * (WIN_W + 1)'({1'b0, n} + (WIN_W + 1)'(1)));
      base <= full ? wsum - WSUM_W'(sum) : wsum;
    end
    if (cmd.take_abs) begin
      neg <= wsum[WSUM_W-1];
      mag <= wsum[WSUM_W-1] ? WSUM_W'(-wsum) : WSUM_W'(wsum);
    end
    if (cmd.num) begin
      // Adding half the divisor rounds to nearest, ties away from zero.
      quo <= {mag, 1'b0} + NUM_W'(den >> 1);
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[NUM_W-2:0], take_bit};
      rem <= take_bit ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign take_bit = (rem_sh >= {1'b0, den});

  assign status.div_last = (int'(cnt) == NUM_W - 1);
  assign status.out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.publish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      res_average <= neg ? -signed'(quo[PW-1:0]) : signed'(quo[PW-1:0]);
      res_window  <= wma_pkg::WIN_FIELD_W'(n);
    end
  end

endmodule

@@ hw/rtl/weighted_moving_average.sv @@
// ----------------------------------------------------------------------------
// weighted_moving_average
// Linearly weighted moving average of signed Q23.8 closing prices, one
// result per bar, with the newest bar weighted by the window length.
// ----------------------------------------------------------------------------
// One bar is handled at a time. After acceptance a bar passes through the
// fetch, multiply, accumulate, absolute-value and numerator steps, then the
// restoring divider, which retires one quotient bit per cycle over the
// rounded numerator of 32 + 2 * ceil(log2(window limit + 1)) + 1 bits,
// which is 51 for a 256-bar ring. Its result is then loaded into an output
// register and the input opens again. A finished result waits in that
// register, so the next bar can be accepted while it is still pending; a bar
// that finishes before that result is taken waits and keeps the input closed.
// Writing the period register, or a bar with restart set, starts a new
// series; the sample ring itself needs no clearing.
module weighted_moving_average #(
  parameter int MAX_PERIOD = wma_pkg::MAX_PERIOD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  wma_bar_if.sink                       bars,
  wma_result_if.source                  results,
  input  logic                          cfg_we,
  input  logic [wma_pkg::PERIOD_W-1:0]  cfg_wdata
);

  wma_pkg::wma_cmd_t    cmd;
  wma_pkg::wma_status_t status;

  wma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bars.valid),
    .in_ready (bars.ready),
    .status   (status),
    .cmd      (cmd)
  );

  wma_datapath #(
    .MAX_PERIOD (MAX_PERIOD)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .price       (bars.price),
    .restart     (bars.restart),
    .res_valid   (results.valid),
    .res_ready   (results.ready),
    .res_average (results.average),
    .res_window  (results.window_used)
  );

endmodule

@@ hw/rtl/wma_checker.sv @@
// ----------------------------------------------------------------------------
// wma_checker
// Port-level checks of the weighted moving average, bound to the top level.
// ----------------------------------------------------------------------------
module wma_checker #(
  parameter int MAX_PERIOD = wma_pkg::MAX_PERIOD_DEF
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [wma_pkg::PRICE_W-1:0]     out_average,
  input logic        [wma_pkg::WIN_FIELD_W-1:0] out_window
);

  // A pending result must not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_average) && $stable(out_window)))
    else $error("result changed or dropped while stalled");

  // Bars are processed one at a time, so acceptance closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again right after a transaction");

  // Every result covers at least one bar.
  a_window_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_window != '0))
    else $error("result with an empty window");

  // The window never exceeds the ring depth.
  a_window_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(out_window) <= MAX_PERIOD))
    else $error("window larger than the sample ring");

endmodule

bind weighted_moving_average wma_checker #(
  .MAX_PERIOD (MAX_PERIOD)
) u_wma_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (bars.valid),
  .in_ready    (bars.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_average (results.average),
  .out_window  (results.window_used)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives price bars into the weighted moving average block and checks every
// average and window size against a running-sum model of the same window, or
// against the table values for typed rows. A short table of directed bars and
// period writes leads; random periods, restarts, gaps and result stalls follow.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PRICE_W       = wma_pkg::PRICE_W;
  localparam int WIN_FIELD_W   = wma_pkg::WIN_FIELD_W;
  localparam int PERIOD_W      = wma_pkg::PERIOD_W;
  localparam int MAX_BARS      = wma_pkg::MAX_PERIOD_DEF;
  localparam int HIST_W        = $clog2(MAX_BARS);
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_BARS   = 2000;
  localparam int HOLD_AT       = 400;   // result count at which the long stall starts
  localparam int HOLD_CYCLES   = 600;

  typedef struct packed {
    logic signed [PRICE_W-1:0]     average;
    logic        [WIN_FIELD_W-1:0] window_used;
  } avg_result_t;

  // One directed row: an optional period write, then one bar.
  typedef struct packed {
    logic                          set_period;
    logic        [PERIOD_W-1:0]    period_value;
    logic signed [PRICE_W-1:0]     price;
    logic                          restart;
    logic                          typed;
    logic signed [PRICE_W-1:0]     average;
    logic        [WIN_FIELD_W-1:0] window_used;
  } bar_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [PERIOD_W-1:0]  cfg_wdata;

  wma_bar_if    bars_if();
  wma_result_if results_if();

  weighted_moving_average u_dut (
    .clk       (clk),
    .rst       (rst),
    .bars      (bars_if),
    .results   (results_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Window model state.
  logic signed [PRICE_W-1:0] price_hist [MAX_BARS];
  int                        hist_ptr;
  int                        win_bars;
  longint                    price_sum;
  longint                    lin_total;
  logic [PERIOD_W-1:0]       period_reg;

  avg_result_t pending_averages[$];
  bar_row_t    directed_bars [DIRECTED_ROWS];
  int          mismatch_count = 0;
  int          bars_sent = 0;
  int          averages_seen = 0;
  bit          tx_no_gaps = 1'b0;

  function automatic void clear_series();
    hist_ptr  = 0;
    win_bars  = 0;
    price_sum = 0;
    lin_total = 0;
  endfunction

  function automatic avg_result_t advance_average(logic signed [PRICE_W-1:0] price,
                                                  logic restart);
    longint      x;
    longint      oldest;
    longint      denom;
    longint      mag;
    longint      q;
    int          lim;
    avg_result_t r;
    x   = longint'(price);
    lim = (period_reg == 0) ? 1 : ((period_reg > MAX_BARS) ? MAX_BARS : int'(period_reg));
    if (restart) begin
      clear_series();
    end
    if (win_bars < lim) begin
      win_bars++;
      lin_total += longint'(win_bars) * x;
      price_sum += x;
    end else begin
      oldest    = longint'(price_hist[HIST_W'((hist_ptr + MAX_BARS - lim) % MAX_BARS)]);
      win_bars  = lim;
      // Every bar loses one unit of weight, the new bar enters at full weight.
      lin_total = lin_total - price_sum + longint'(lim) * x;
      price_sum = price_sum - oldest + x;
    end
    price_hist[HIST_W'(hist_ptr)] = price;
    hist_ptr = (hist_ptr + 1) % MAX_BARS;

    denom = longint'(win_bars) * longint'(win_bars + 1) / 2;
    mag   = (lin_total < 0) ? -lin_total : lin_total;
    q     = (2 * mag + denom) / (2 * denom);
    if (lin_total < 0) begin
      q = -q;
    end
    r.average     = q[PRICE_W-1:0];
    r.window_used = win_bars[WIN_FIELD_W-1:0];
    return r;
  endfunction

  // Returns at the edge that took the bar, with valid still high, so the next
  // call decides in the same step whether valid drops or carries a new bar.
  task automatic send_bar(logic signed [PRICE_W-1:0] price, logic restart,
                          bit typed, avg_result_t typed_result);
    int          gap;
    avg_result_t predicted;
    if (bars_sent % 50 == 0) begin
      tx_no_gaps = ($urandom_range(0, 3) == 0);
    end
    gap = tx_no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      bars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bars_if.valid   <= 1'b1;
    bars_if.price   <= price;
    bars_if.restart <= restart;
    do @(posedge clk); while (!bars_if.ready);
    predicted = advance_average(price, restart);
    pending_averages.push_back(typed ? typed_result : predicted);
    bars_sent++;
  endtask

  // The block is idle once every average has come back out.
  task automatic write_period(logic [PERIOD_W-1:0] value);
    bars_if.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    period_reg = value;
    clear_series();
  endtask

  initial begin : stimulus
    logic signed [PRICE_W-1:0] price;
    logic                      restart;
    logic [PERIOD_W-1:0]       new_period;
    avg_result_t               typed_result;
    int                        phase_len;
    int                        k;
    bit                        rail_phase;

    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    bars_if.valid   <= 1'b0;
    bars_if.price   <= '0;
    bars_if.restart <= 1'b0;
    period_reg = PERIOD_W'(wma_pkg::PERIOD_RESET);
    clear_series();

    directed_bars = '{
      '{1'b0, 9'd0,   32'sd0,           1'b0, 1'b1, 32'sd0,           9'd1},
      '{1'b0, 9'd0,   32'sh7FFFFFFF,    1'b0, 1'b0, 32'sd0,           9'd0},
      '{1'b0, 9'd0,   32'sh80000000,    1'b0, 1'b0, 32'sd0,           9'd0},
      '{1'b0, 9'd0,   32'sh7FFFFFFF,    1'b1, 1'b1, 32'sh7FFFFFFF,    9'd1},
      '{1'b0, 9'd0,   32'sh80000000,    1'b1, 1'b1, 32'sh80000000,    9'd1},
      '{1'b0, 9'd0,   32'sh80000000,    1'b0, 1'b1, 32'sh80000000,    9'd2},
      // A zero period acts as a one-bar window.
      '{1'b1, 9'd0,   32'sd12345,       1'b0, 1'b1, 32'sd12345,       9'd1},
      '{1'b0, 9'd0,   -32'sd5,          1'b0, 1'b1, -32'sd5,          9'd1},
      '{1'b1, 9'd1,   32'sh7FFFFFFF,    1'b0, 1'b1, 32'sh7FFFFFFF,    9'd1},
      '{1'b0, 9'd0,   32'sh55555555,    1'b0, 1'b1, 32'sh55555555,    9'd1},
      // Periods above the ring size saturate to the ring size.
      '{1'b1, 9'd511, 32'sd1,           1'b0, 1'b1, 32'sd1,           9'd1},
      '{1'b0, 9'd0,   32'sd2,           1'b0, 1'b0, 32'sd0,           9'd0},
      '{1'b0, 9'd0,   -32'sd1,          1'b0, 1'b0, 32'sd0,           9'd0},
      '{1'b1, 9'd257, 32'sh80000000,    1'b0, 1'b1, 32'sh80000000,    9'd1},
      '{1'b0, 9'd0,   32'sh80000000,    1'b0, 1'b1, 32'sh80000000,    9'd2},
      // Window of three: the third bar lands exactly on a half step.
      '{1'b1, 9'd3,   32'sd1,           1'b0, 1'b1, 32'sd1,           9'd1},
      '{1'b0, 9'd0,   32'sd1,           1'b0, 1'b1, 32'sd1,           9'd2},
      '{1'b0, 9'd0,   32'sd0,           1'b0, 1'b0, 32'sd0,           9'd0},
      '{1'b0, 9'd0,   -32'sd1,          1'b1, 1'b1, -32'sd1,          9'd1},
      '{1'b0, 9'd0,   -32'sd1,          1'b0, 1'b1, -32'sd1,          9'd2},
      '{1'b0, 9'd0,   32'sd0,           1'b0, 1'b0, 32'sd0,           9'd0},
      '{1'b0, 9'd0,   32'sd7,           1'b0, 1'b0, 32'sd0,           9'd0},
      '{1'b1, 9'd256, 32'sh7FFFFFFF,    1'b0, 1'b1, 32'sh7FFFFFFF,    9'd1},
      '{1'b1, 9'd2,   32'sd3,           1'b0, 1'b1, 32'sd3,           9'd1},
      '{1'b0, 9'd0,   -32'sd3,          1'b0, 1'b0, 32'sd0,           9'd0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_bars[i]) begin
      if (directed_bars[i].set_period) begin
        write_period(directed_bars[i].period_value);
      end
      typed_result.average     = directed_bars[i].average;
      typed_result.window_used = directed_bars[i].window_used;
      send_bar(directed_bars[i].price, directed_bars[i].restart,
               directed_bars[i].typed, typed_result);
    end

    while (bars_sent < DIRECTED_ROWS + RANDOM_BARS) begin
      case ($urandom_range(0, 9))
        0:       new_period = 9'd0;
        1:       new_period = 9'd256;
        2:       new_period = PERIOD_W'($urandom_range(257, 511));
        3:       new_period = 9'd1;
        4, 5, 6: new_period = PERIOD_W'($urandom_range(2, 16));
        7, 8:    new_period = PERIOD_W'($urandom_range(17, 64));
        default: new_period = PERIOD_W'($urandom_range(65, 255));
      endcase
      write_period(new_period);
      rail_phase = ($urandom_range(0, 5) == 0);
      phase_len  = $urandom_range(60, 320);
      if (new_period >= 200) begin
        phase_len += 300;   // long enough to slide a full window around the ring
      end
      for (k = 0; k < phase_len && bars_sent < DIRECTED_ROWS + RANDOM_BARS; k++) begin
        if (rail_phase) begin
          price = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
        end else begin
          case ($urandom_range(0, 7))
            0:       price = 32'sh7FFFFFFF;
            1:       price = 32'sh80000000;
            2, 3:    price = $urandom;
            default: begin
              price = $urandom_range(0, 51200);
              price = price - 32'sd25600;
            end
          endcase
        end
        restart = ($urandom_range(0, 39) == 0);
        send_bar(price, restart, 1'b0, typed_result);
      end
    end

    bars_if.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : collect_averages
    int          gap;
    bit          rx_no_gaps;
    bit          held;
    avg_result_t want;
    rx_no_gaps = 1'b0;
    held       = 1'b0;
    results_if.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (averages_seen % 50 == 0) begin
        rx_no_gaps = ($urandom_range(0, 3) == 0);
      end
      gap = rx_no_gaps ? 0 : $urandom_range(0, 13);
      // One long stall lets the block fill up and push back on incoming bars.
      if (averages_seen == HOLD_AT && !held) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        results_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (!results_if.valid);
      averages_seen++;
      if (pending_averages.size() == 0) begin
        $error("unexpected transaction: average %0d, window_used %0d",
               results_if.average, results_if.window_used);
        mismatch_count++;
      end else begin
        want = pending_averages.pop_front();
        if (results_if.average !== want.average) begin
          $error("average: expected %0d, actual %0d", want.average, results_if.average);
          mismatch_count++;
        end
        if (results_if.window_used !== want.window_used) begin
          $error("window_used: expected %0d, actual %0d",
                 want.window_used, results_if.window_used);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
